### rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int DataWidth   = 16;
    localparam int FracBits    = 14;
    localparam int SumWidth    = DataWidth + 3;
    localparam int NumWidth    = DataWidth + 1;
    localparam int ArgWidth    = DataWidth + 1;
    localparam int RadWidth    = ArgWidth + FracBits + 1;
    localparam int RootWidth   = RadWidth / 2;
    localparam int SqRemWidth  = RootWidth + 4;
    localparam int DenWidth    = RootWidth + 1;
    localparam int DivNumWidth = NumWidth + FracBits;
    localparam int QuotWidth   = DivNumWidth - (FracBits / 2 + 1);
    localparam int DivRemWidth = DenWidth + 1;
    localparam int Lanes       = 3;
    localparam int FrontStages = 3;
    localparam int Latency     = FrontStages + RootWidth + 1 + QuotWidth + 1;

    localparam logic [1:0] CompW = 2'd0;
    localparam logic [1:0] CompX = 2'd1;
    localparam logic [1:0] CompY = 2'd2;
    localparam logic [1:0] CompZ = 2'd3;

    typedef struct packed {
        logic signed [DataWidth-1:0] r00;
        logic signed [DataWidth-1:0] r01;
        logic signed [DataWidth-1:0] r02;
        logic signed [DataWidth-1:0] r10;
        logic signed [DataWidth-1:0] r11;
        logic signed [DataWidth-1:0] r12;
        logic signed [DataWidth-1:0] r20;
        logic signed [DataWidth-1:0] r21;
        logic signed [DataWidth-1:0] r22;
    } matrix_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] quat_w;
        logic signed [DataWidth-1:0] quat_x;
        logic signed [DataWidth-1:0] quat_y;
        logic signed [DataWidth-1:0] quat_z;
        logic                        invalid;
    } result_t;

endpackage

### rtl/rotation_matrix_to_quaternion.sv
// Channel   Ports                 Direction  Transfer
// input     start, busy, matrix   in         start high while busy low
// result    done, quat            out        one cycle, marked by done
//
// Every transaction returns its result after the select, prepare, square-root, divider and output registers.
// One transaction may be accepted in every cycle; busy stays low.
// The latency is set by the square root, one root bit per stage, and the
// three parallel dividers, one quotient bit per stage.
// Reset clears the valid bits of all stages and drops transactions in flight.
// The receiver cannot stall, so results leave on the cycle they are ready.
module rotation_matrix_to_quaternion (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rmq_pkg::matrix_t matrix,
    output logic             done,
    output rmq_pkg::result_t quat
);

    localparam int DW   = rmq_pkg::DataWidth;
    localparam int FB   = rmq_pkg::FracBits;
    localparam int SW   = rmq_pkg::SumWidth;
    localparam int NW   = rmq_pkg::NumWidth;
    localparam int AW   = rmq_pkg::ArgWidth;
    localparam int RW   = rmq_pkg::RadWidth;
    localparam int TW   = rmq_pkg::RootWidth;
    localparam int QRW  = rmq_pkg::SqRemWidth;
    localparam int DNW  = rmq_pkg::DenWidth;
    localparam int NMW  = rmq_pkg::DivNumWidth;
    localparam int QW   = rmq_pkg::QuotWidth;
    localparam int DRW  = rmq_pkg::DivRemWidth;
    localparam int LN   = rmq_pkg::Lanes;
    localparam logic signed [SW-1:0] OneVal = SW'(1) <<< FB;

    typedef struct packed {
        logic                        tpos;
        logic [1:0]                  axis;
        rmq_pkg::matrix_t            mat;
    } sel_t;

    typedef struct packed {
        logic [1:0]                  main;
        logic                        inv;
        logic signed [SW-1:0]        arg;
        logic [LN-1:0][NW-1:0]       num;
    } prep_t;

    typedef struct packed {
        logic [1:0]                  main;
        logic                        inv;
        logic [LN-1:0]               neg;
        logic [LN-1:0][NW-1:0]       mag;
        logic [RW-1:0]               rad;
        logic [QRW-1:0]              rem;
        logic [TW-1:0]               root;
    } sq_t;

    typedef struct packed {
        logic [1:0]                  main;
        logic                        inv;
        logic [LN-1:0]               neg;
        logic [TW-1:0]               half;
        logic [DNW-1:0]              den;
        logic [LN-1:0][QW-1:0]       num;
        logic [LN-1:0][DRW-1:0]      rem;
        logic [LN-1:0][QW-1:0]       quo;
    } dv_t;

    function automatic logic signed [DW-1:0] sat_lane(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        logic signed [DW-1:0] res;
        lim = QW'(1) << (DW - 1);
        if (neg) begin
            if (q > lim) begin
                res = {1'b1, {(DW-1){1'b0}}};
            end else begin
                res = -$signed(DW'(q));
            end
        end else begin
            if (q >= lim) begin
                res = {1'b0, {(DW-1){1'b1}}};
            end else begin
                res = $signed(DW'(q));
            end
        end
        return res;
    endfunction

    assign busy = 1'b0;

    logic sel_valid_reg;
    sel_t sel_reg;
    sel_t sel_next;

    always_comb
    begin
        logic signed [SW-1:0] trace;
        logic signed [DW-1:0] dmax;
        trace = SW'(matrix.r00) + SW'(matrix.r11) + SW'(matrix.r22);
        sel_next.mat  = matrix;
        sel_next.tpos = (trace > 0);
        sel_next.axis = 2'd0;
        dmax          = matrix.r00;
        if (matrix.r11 > matrix.r00) begin
            sel_next.axis = 2'd1;
            dmax          = matrix.r11;
        end
        if (matrix.r22 > dmax) begin
            sel_next.axis = 2'd2;
        end
    end

    logic  prep_valid_reg;
    prep_t prep_reg;
    prep_t prep_next;

    always_comb
    begin
        logic signed [SW-1:0] a00;
        logic signed [SW-1:0] a11;
        logic signed [SW-1:0] a22;
        rmq_pkg::matrix_t m;
        m   = sel_reg.mat;
        a00 = SW'(m.r00);
        a11 = SW'(m.r11);
        a22 = SW'(m.r22);
        prep_next.inv = 1'b0;
        if (sel_reg.tpos) begin
            prep_next.main   = rmq_pkg::CompW;
            prep_next.arg    = a00 + a11 + a22 + OneVal;
            prep_next.num[0] = NW'(m.r21) - NW'(m.r12);
            prep_next.num[1] = NW'(m.r02) - NW'(m.r20);
            prep_next.num[2] = NW'(m.r10) - NW'(m.r01);
        end else begin
            unique case (sel_reg.axis)
                2'd0:
                begin
                    prep_next.main   = rmq_pkg::CompX;
                    prep_next.arg    = a00 - a11 - a22 + OneVal;
                    prep_next.num[0] = NW'(m.r21) - NW'(m.r12);
                    prep_next.num[1] = NW'(m.r10) + NW'(m.r01);
                    prep_next.num[2] = NW'(m.r20) + NW'(m.r02);
                end
                2'd1:
                begin
                    prep_next.main   = rmq_pkg::CompY;
                    prep_next.arg    = a11 - a22 - a00 + OneVal;
                    prep_next.num[0] = NW'(m.r02) - NW'(m.r20);
                    prep_next.num[1] = NW'(m.r01) + NW'(m.r10);
                    prep_next.num[2] = NW'(m.r21) + NW'(m.r12);
                end
                default:
                begin
                    prep_next.main   = rmq_pkg::CompZ;
                    prep_next.arg    = a22 - a00 - a11 + OneVal;
                    prep_next.num[0] = NW'(m.r10) - NW'(m.r01);
                    prep_next.num[1] = NW'(m.r02) + NW'(m.r20);
                    prep_next.num[2] = NW'(m.r12) + NW'(m.r21);
                end
            endcase
            prep_next.inv = (prep_next.arg <= 0);
        end
    end

    logic [TW:0] sq_valid_reg;
    sq_t         sq_reg [TW+1];
    sq_t         sq_next [TW+1];

    always_comb
    begin
        sq_next[0].main = prep_reg.main;
        sq_next[0].inv  = prep_reg.inv;
        for (int l = 0; l < LN; l++) begin
            sq_next[0].neg[l] = prep_reg.num[l][NW-1];
            sq_next[0].mag[l] = prep_reg.num[l][NW-1] ? NW'(-prep_reg.num[l]) : prep_reg.num[l];
        end
        sq_next[0].rad  = {1'b0, prep_reg.arg[AW-1:0], {FB{1'b0}}};
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
    end

    for (genvar k = 1; k <= TW; k++) begin : g_sqrt
        always_comb
        begin
            logic [QRW-1:0] rem_sh;
            logic [QRW-1:0] trial;
            sq_next[k]     = sq_reg[k-1];
            rem_sh         = {sq_reg[k-1].rem[QRW-3:0], sq_reg[k-1].rad[RW-1 -: 2]};
            trial          = QRW'({sq_reg[k-1].root, 2'b01});
            sq_next[k].rad = sq_reg[k-1].rad << 2;
            if (rem_sh >= trial) begin
                sq_next[k].rem  = rem_sh - trial;
                sq_next[k].root = {sq_reg[k-1].root[TW-2:0], 1'b1};
            end else begin
                sq_next[k].rem  = rem_sh;
                sq_next[k].root = {sq_reg[k-1].root[TW-2:0], 1'b0};
            end
        end
    end

    logic [QW:0] dv_valid_reg;
    dv_t         dv_reg [QW+1];
    dv_t         dv_next [QW+1];

    always_comb
    begin
        logic [NMW-1:0] full;
        logic [TW:0]    rp1;
        sq_t            s;
        s = sq_reg[TW];
        rp1 = {1'b0, s.root} + (TW+1)'(1);
        dv_next[0].main = s.main;
        dv_next[0].inv  = s.inv;
        dv_next[0].neg  = s.neg;
        dv_next[0].half = rp1[TW:1];
        dv_next[0].den  = {s.root, 1'b0};
        for (int l = 0; l < LN; l++) begin
            full              = {s.mag[l], {FB{1'b0}}} + NMW'(s.root);
            dv_next[0].num[l] = full[QW-1:0];
            dv_next[0].rem[l] = DRW'(full[NMW-1:QW]);
            dv_next[0].quo[l] = '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_comb
        begin
            logic [DRW-1:0] rem_sh;
            dv_next[k] = dv_reg[k-1];
            for (int l = 0; l < LN; l++) begin
                rem_sh            = {dv_reg[k-1].rem[l][DRW-2:0], dv_reg[k-1].num[l][QW-1]};
                dv_next[k].num[l] = dv_reg[k-1].num[l] << 1;
                if (rem_sh >= DRW'(dv_reg[k-1].den)) begin
                    dv_next[k].rem[l] = rem_sh - DRW'(dv_reg[k-1].den);
                    dv_next[k].quo[l] = {dv_reg[k-1].quo[l][QW-2:0], 1'b1};
                end else begin
                    dv_next[k].rem[l] = rem_sh;
                    dv_next[k].quo[l] = {dv_reg[k-1].quo[l][QW-2:0], 1'b0};
                end
            end
        end
    end

    logic    done_reg;
    rmq_pkg::result_t quat_reg;
    rmq_pkg::result_t quat_next;

    always_comb
    begin
        logic signed [DW-1:0] mainv;
        logic signed [DW-1:0] l0;
        logic signed [DW-1:0] l1;
        logic signed [DW-1:0] l2;
        dv_t d;
        d = dv_reg[QW];
        if (d.half[TW-1]) begin
            mainv = {1'b0, {(DW-1){1'b1}}};
        end else begin
            mainv = $signed(DW'(d.half));
        end
        l0 = sat_lane(d.neg[0], d.quo[0]);
        l1 = sat_lane(d.neg[1], d.quo[1]);
        l2 = sat_lane(d.neg[2], d.quo[2]);
        unique case (d.main)
            rmq_pkg::CompW: quat_next = {mainv, l0, l1, l2, 1'b0};
            rmq_pkg::CompX: quat_next = {l0, mainv, l1, l2, 1'b0};
            rmq_pkg::CompY: quat_next = {l0, l1, mainv, l2, 1'b0};
            default:        quat_next = {l0, l1, l2, mainv, 1'b0};
        endcase
        if (d.inv) begin
            quat_next = '0;
            quat_next.invalid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_valid_reg  <= 1'b0;
            prep_valid_reg <= 1'b0;
            sq_valid_reg   <= '0;
            dv_valid_reg   <= '0;
            done_reg       <= 1'b0;
        end else begin
            sel_valid_reg  <= start && !busy;
            prep_valid_reg <= sel_valid_reg;
            sq_valid_reg   <= {sq_valid_reg[TW-1:0], prep_valid_reg};
            dv_valid_reg   <= {dv_valid_reg[QW-1:0], sq_valid_reg[TW]};
            done_reg       <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        prep_reg <= prep_next;
        for (int k = 0; k <= TW; k++) begin
            sq_reg[k] <= sq_next[k];
        end
        for (int k = 0; k <= QW; k++) begin
            dv_reg[k] <= dv_next[k];
        end
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

endmodule

### rtl/rmq_checker.sv
module rmq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input rmq_pkg::result_t quat
);

    localparam int Lat = rmq_pkg::Latency;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline never stalls");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Lat))
        else $error("result without a transaction accepted at the pipeline latency");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && quat.invalid) |-> (quat.quat_w == 0 && quat.quat_x == 0 &&
                                    quat.quat_y == 0 && quat.quat_z == 0))
        else $error("invalid result carries a nonzero quaternion");

    a_trace_main_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !quat.invalid) |-> (!quat.quat_w[rmq_pkg::DataWidth-1] ||
            !quat.quat_x[rmq_pkg::DataWidth-1] || !quat.quat_y[rmq_pkg::DataWidth-1] ||
            !quat.quat_z[rmq_pkg::DataWidth-1]))
        else $error("valid result has no nonnegative component");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .quat   (quat)
);

### dv/tb_rotation_matrix_to_quaternion.sv
module tb_rotation_matrix_to_quaternion;

    localparam int DW          = rmq_pkg::DataWidth;
    localparam int MW          = $bits(rmq_pkg::matrix_t);
    localparam int RandomItems = 600;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = rmq_pkg::Latency + 20;

    typedef struct {
        rmq_pkg::matrix_t m;
        bit               has_known;
        rmq_pkg::result_t known;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    rmq_pkg::matrix_t matrix;
    logic             done;
    rmq_pkg::result_t quat;

    rmq_pkg::result_t pending_quats[$];
    row_t             rows[$];
    int               error_count;
    int               cycle_count;

    rotation_matrix_to_quaternion u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .matrix (matrix),
        .done   (done),
        .quat   (quat)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint sat_q(longint v);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < -hi - 1)
        begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint div_by_root(longint d, longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << rmq_pkg::FracBits) + root) / (root << 1);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic rmq_pkg::result_t quaternion_of(rmq_pkg::matrix_t mt);
        longint           e[3][3];
        longint           q[4];
        longint           one;
        longint           s;
        longint           tr;
        longint unsigned  root;
        int               i;
        int               j;
        int               k;
        rmq_pkg::result_t res;
        e[0][0] = mt.r00; e[0][1] = mt.r01; e[0][2] = mt.r02;
        e[1][0] = mt.r10; e[1][1] = mt.r11; e[1][2] = mt.r12;
        e[2][0] = mt.r20; e[2][1] = mt.r21; e[2][2] = mt.r22;
        q = '{0, 0, 0, 0};
        one = longint'(1) << rmq_pkg::FracBits;
        res.invalid = 1'b0;
        tr = e[0][0] + e[1][1] + e[2][2];
        if (tr > 0)
        begin
            root = int_sqrt(longint'(tr + one) << rmq_pkg::FracBits);
            q[0] = longint'((root + 1) >> 1);
            q[1] = div_by_root(e[2][1] - e[1][2], root);
            q[2] = div_by_root(e[0][2] - e[2][0], root);
            q[3] = div_by_root(e[1][0] - e[0][1], root);
        end
        else
        begin
            i = 0;
            if (e[1][1] > e[0][0])
            begin
                i = 1;
            end
            if (e[2][2] > e[i][i])
            begin
                i = 2;
            end
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            s = e[i][i] - e[j][j] - e[k][k] + one;
            if (s <= 0)
            begin
                res.invalid = 1'b1;
            end
            else
            begin
                root = int_sqrt(longint'(s) << rmq_pkg::FracBits);
                q[1 + i] = longint'((root + 1) >> 1);
                q[0] = div_by_root(e[k][j] - e[j][k], root);
                q[1 + j] = div_by_root(e[j][i] + e[i][j], root);
                q[1 + k] = div_by_root(e[k][i] + e[i][k], root);
            end
        end
        res.quat_w = DW'(sat_q(q[0]));
        res.quat_x = DW'(sat_q(q[1]));
        res.quat_y = DW'(sat_q(q[2]));
        res.quat_z = DW'(sat_q(q[3]));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        rmq_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_quats.size() == 0)
            begin
                report_mismatch("transactions pending", 0, 1);
            end
            else
            begin
                want = pending_quats.pop_front();
                if (quat.quat_w !== want.quat_w)
                    report_mismatch("quat_w", quat.quat_w, want.quat_w);
                if (quat.quat_x !== want.quat_x)
                    report_mismatch("quat_x", quat.quat_x, want.quat_x);
                if (quat.quat_y !== want.quat_y)
                    report_mismatch("quat_y", quat.quat_y, want.quat_y);
                if (quat.quat_z !== want.quat_z)
                    report_mismatch("quat_z", quat.quat_z, want.quat_z);
                if (quat.invalid !== want.invalid)
                    report_mismatch("invalid", quat.invalid, want.invalid);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic rmq_pkg::matrix_t make_matrix(int a00, int a01, int a02, int a10,
                                                     int a11, int a12, int a20, int a21,
                                                     int a22);
        rmq_pkg::matrix_t mt;
        mt = '{DW'(a00), DW'(a01), DW'(a02), DW'(a10), DW'(a11),
               DW'(a12), DW'(a20), DW'(a21), DW'(a22)};
        return mt;
    endfunction

    task automatic add_row(rmq_pkg::matrix_t mt, bit known_flag, rmq_pkg::result_t kq);
        row_t rw;
        rw.m = mt;
        rw.has_known = known_flag;
        rw.known = kq;
        rows.push_back(rw);
    endtask

    function automatic logic [15:0] rand_entry();
        unique case ($urandom_range(0, 5))
            0: return 16'(16384 - $urandom_range(0, 200));
            1: return 16'(-16384 + $urandom_range(0, 200));
            2: return 16'($urandom_range(0, 400) - 200);
            3: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic rmq_pkg::matrix_t random_matrix();
        rmq_pkg::matrix_t mt;
        int               p;
        int               sg;
        mt = MW'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 3) != 0)
        begin
            mt = '{rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                   rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        end
        if ($urandom_range(0, 1) != 0)
        begin
            // Near a signed permutation, so each branch of the trace method is reached.
            mt = '{9{16'sd0}};
            p = $urandom_range(0, 3);
            sg = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
            mt.r00 = DW'((p == 0) ? 16384 : -16384);
            mt.r11 = DW'((p == 1) ? 16384 : -16384);
            mt.r22 = DW'((p == 2) ? 16384 : -16384);
            if (p == 3)
            begin
                mt.r00 = DW'(16384); mt.r11 = DW'(16384); mt.r22 = DW'(16384);
            end
            mt.r01 = 16'($urandom_range(0, 2000) - 1000);
            mt.r10 = sg == 16384 ? mt.r01 : -mt.r01;
            mt.r12 = 16'($urandom_range(0, 2000) - 1000);
            mt.r21 = 16'($urandom_range(0, 2000) - 1000);
            mt.r02 = 16'($urandom_range(0, 2000) - 1000);
            mt.r20 = 16'($urandom_range(0, 2000) - 1000);
            mt.r00 = mt.r00 - 16'($urandom_range(0, 300));
            mt.r11 = mt.r11 - 16'($urandom_range(0, 300));
            mt.r22 = mt.r22 - 16'($urandom_range(0, 300));
        end
        return mt;
    endfunction

    task automatic send_matrix(rmq_pkg::matrix_t mt, bit known_flag, rmq_pkg::result_t kq);
        rmq_pkg::result_t want;
        want = quaternion_of(mt);
        if (known_flag && want !== kq)
        begin
            report_mismatch("predictor against table", 0, 1);
        end
        start <= 1'b1;
        matrix <= mt;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_quats.push_back(known_flag ? kq : want);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        start <= 1'b0;
        matrix <= MW'({$urandom, $urandom, $urandom, $urandom, $urandom});
        repeat ($urandom_range(1, 6))
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int               burst;
        int               drain;
        rmq_pkg::result_t kq;
        error_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        matrix = '0;
        kq = '0;
        add_row(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1, '{16384, 0, 0, 0, 0});
        add_row(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1, '{0, 16384, 0, 0, 0});
        add_row(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1, '{0, 0, 16384, 0, 0});
        add_row(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1, '{0, 0, 0, 16384, 0});
        add_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, kq);
        add_row(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1, '{0, 14189, 0, 0, 0});
        add_row(make_matrix(-20000, 0, 0, 0, -20000, 0, 0, 0, 0), 0, kq);
        add_row(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, kq);
        add_row(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768), 0, kq);
        add_row(make_matrix(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0), 0, kq);
        add_row(make_matrix(-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768,
                            -16384), 0, kq);
        add_row(make_matrix(-100, 32767, 32767, 32767, -100, 32767, 32767, 32767, -100), 0, kq);
        add_row(make_matrix(0, 1000, 0, -1000, 0, 0, 0, 0, 0), 0, kq);
        add_row(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, -32768), 0, kq);
        add_row(make_matrix(-32768, 0, 0, 0, 32767, -32768, 0, 32767, -32768), 0, kq);
        add_row(make_matrix(-5, 32767, -32768, 32767, -5, -32768, 32767, 32767, -6), 0, kq);
        add_row(make_matrix(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384), 0, kq);
        repeat (4)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[n])
        begin
            send_matrix(rows[n].m, rows[n].has_known, rows[n].known);
        end
        burst = 0;
        for (int n = 0; n < RandomItems; n++)
        begin
            if (burst == 0)
            begin
                idle_gap();
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            end
            send_matrix(random_matrix(), 0, kq);
            burst--;
        end
        start <= 1'b0;
        drain = 0;
        while (pending_quats.size() != 0 || drain < DrainCycles)
        begin
            @(posedge clk);
            drain = (pending_quats.size() == 0) ? drain + 1 : 0;
        end
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
